/* design/lock_order_witness_tracker_core_assert.svh */
// Assertion macros for the lock order witness tracker core module.
`ifndef LOCK_ORDER_WITNESS_TRACKER_CORE_ASSERT_SVH
`define LOCK_ORDER_WITNESS_TRACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LOWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LOWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LOWT_ASSERT(lbl, prop, msg)
`define LOWT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/lowt_pkg.sv */
// Shared types and constants of the lock order witness tracker.
`timescale 1ns / 1ps
package lowt_pkg;
    localparam int CNT_W = 6;
    localparam logic [31:0] HASH_MUL = 32'd2654435761;

    localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    localparam logic [2:0] KIND_INV     = 3'd0;
    localparam logic [2:0] KIND_ACQUIRE = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;

    localparam logic [1:0] ADDR_TRACK_ENABLE = 2'd0;

    typedef struct packed {
        logic [31:0] lock_id;
        logic [15:0] lock_class;
        logic        lock_mode;
    } held_entry_t;
endpackage

/* design/lowt_hash.sv */
// Multiplicative hash reduced to a slot index by keeping the low product bits.
`timescale 1ns / 1ps
module lowt_hash #(
    parameter int EDGE_SLOTS = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [31:0]                   key,
    output logic                          done,
    output logic [$clog2(EDGE_SLOTS)-1:0] slot
);
    import lowt_pkg::*;

    localparam int EW = $clog2(EDGE_SLOTS);

    logic [EW-1:0] slot_reg, slot_next;
    logic          done_reg;

    // Product modulo 2^32, then modulo the power-of-two slot count
    assign slot_next = EW'(key * HASH_MUL);

    // Strobe done in the cycle after go
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= go;
        end
    end

    // Capture the slot
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            slot_reg <= slot_next;
        end
    end

    assign done = done_reg;
    assign slot = slot_reg;
endmodule

/* design/lowt_edge_store.sv */
// Edge hash table memory with a clearing sweep.
`timescale 1ns / 1ps
module lowt_edge_store #(
    parameter int EDGE_SLOTS = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [$clog2(EDGE_SLOTS)-1:0] rd_addr,
    output logic [31:0]                   rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(EDGE_SLOTS)-1:0] wr_addr,
    input  logic [31:0]                   wr_data,
    input  logic                          clr_start,
    output logic                          clr_busy
);
    localparam int EW = $clog2(EDGE_SLOTS);
    localparam logic [EW-1:0] LAST_SLOT = EW'(EDGE_SLOTS - 1);

    logic [31:0]   mem [EDGE_SLOTS];
    logic [31:0]   rd_data_reg;
    logic [EW-1:0] sweep_reg;
    logic          busy_reg;

    // Advance the sweep; reset starts one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (clr_start)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (busy_reg)
        begin
            sweep_reg <= sweep_reg + EW'(1);
            if (sweep_reg == LAST_SLOT)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Write and read the table
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[sweep_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = busy_reg;
endmodule

/* design/lowt_held_store.sv */
// Held lock list memory.
`timescale 1ns / 1ps
module lowt_held_store #(
    parameter int HELD_SLOTS = 32,
    parameter int HW = 5
) (
    input  logic                  clk,
    input  logic [HW-1:0]         rd_addr,
    output lowt_pkg::held_entry_t rd_data,
    input  logic                  wr_en,
    input  logic [HW-1:0]         wr_addr,
    input  lowt_pkg::held_entry_t wr_data
);
    import lowt_pkg::*;

    held_entry_t mem [HELD_SLOTS];
    held_entry_t rd_data_reg;

    // Write and read the list
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

/* design/lock_order_witness_tracker_core.sv */
// Top level of the lock order witness tracker: sequencer, handshakes, register port.
//
// One input item is taken at a time. Query and release read and check each held entry
// visited in turn; release then moves the tail entry into the gap when the entry found
// is not the tail, and both finish by loading the answer. An acquire with tracking on,
// for each held entry of another class, reads the entry, hashes the edge key and probes
// the edge table slot by slot for the lookup, hashes and probes again for the insert,
// and advances; a lookup hit is reported as an inversion before the insert. An entry of
// the same class is only read and skipped. A clear answers first, then sweeps the edge
// table, one slot per cycle, and the same sweep runs after reset; no item is taken
// during a sweep. EDGE_SLOTS must be a power of two.
`timescale 1ns / 1ps
`include "lock_order_witness_tracker_core_assert.svh"
module lock_order_witness_tracker_core #(
    parameter int EDGE_SLOTS = 8192,
    parameter int HELD_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] lock_id,
    input  logic [15:0] lock_class,
    input  logic        lock_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic        last,
    output logic [15:0] earlier_class,
    output logic [15:0] later_class,
    output logic        ok,
    output logic        found_mode,
    output logic        mode_match,
    output logic [31:0] inversion_total,
    output logic [5:0]  held_now
);
    import lowt_pkg::*;

    localparam int EW = $clog2(EDGE_SLOTS);
    localparam int HW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
    localparam logic [EW-1:0] LAST_SLOT = EW'(EDGE_SLOTS - 1);
    localparam logic [CNT_W-1:0] HELD_MAX = CNT_W'(HELD_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD, S_A_CHK, S_HASH, S_P_RD, S_P_CHK, S_INV, S_A_NEXT,
        S_PUSH, S_R_RD, S_R_CHK, S_R_MOVE, S_Q_RD, S_Q_CHK, S_ANSWER, S_C_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        func_reg, func_next;
    logic [31:0]       id_reg, id_next;
    logic [15:0]       cls_reg, cls_next;
    logic              mode_reg, mode_next;
    logic [HW-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       a_reg, a_next;
    logic [31:0]       key_reg, key_next;
    logic              lookup_reg, lookup_next;
    logic [EW-1:0]     slot_reg, slot_next;
    logic [EW-1:0]     probe_reg, probe_next;
    logic [31:0]       inv_reg, inv_next;
    logic              track_reg;
    logic              hash_go_reg, hash_go_next;
    logic              ans_ok_reg, ans_ok_next;
    logic              ans_fm_reg, ans_fm_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;
    logic [15:0]       out_ecl_reg, out_ecl_next;
    logic [15:0]       out_lcl_reg, out_lcl_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_fm_reg, out_fm_next;
    logic              out_mm_reg, out_mm_next;
    logic [31:0]       out_inv_reg, out_inv_next;
    logic [CNT_W-1:0]  out_held_reg, out_held_next;

    logic              out_free;
    logic              in_take;
    logic              can_push;
    logic [CNT_W-1:0]  acq_final;
    logic [CNT_W-1:0]  idx_wide;
    logic [CNT_W-1:0]  count_less;
    logic              inv_out;

    logic              hash_done;
    logic [EW-1:0]     hash_slot;
    logic [EW-1:0]     edge_rd_addr;
    logic [31:0]       edge_rd_data;
    logic              edge_wr_en;
    logic              clr_start;
    logic              clr_busy;
    logic [HW-1:0]     held_rd_addr;
    held_entry_t       held_rd_data;
    logic              held_wr_en;
    logic [HW-1:0]     held_wr_addr;
    held_entry_t       held_wr_data;

    lowt_hash #(.EDGE_SLOTS(EDGE_SLOTS)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (hash_go_reg),
        .key   (key_reg),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    lowt_edge_store #(.EDGE_SLOTS(EDGE_SLOTS)) u_edges (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (edge_rd_addr),
        .rd_data   (edge_rd_data),
        .wr_en     (edge_wr_en),
        .wr_addr   (slot_reg),
        .wr_data   (key_reg),
        .clr_start (clr_start),
        .clr_busy  (clr_busy)
    );

    lowt_held_store #(.HELD_SLOTS(HELD_SLOTS), .HW(HW)) u_held (
        .clk     (clk),
        .rd_addr (held_rd_addr),
        .rd_data (held_rd_data),
        .wr_en   (held_wr_en),
        .wr_addr (held_wr_addr),
        .wr_data (held_wr_data)
    );

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TRACK_ENABLE) ? {31'd0, track_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_TRACK_ENABLE)
        begin
            track_reg <= pwdata[0];
        end
    end

    // Handshake and helpers
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != S_IDLE) || clr_busy;
    assign in_take    = in_valid && !in_stall;
    assign can_push   = count_reg < HELD_MAX;
    assign acq_final  = count_reg + CNT_W'(can_push);
    assign idx_wide   = CNT_W'(idx_reg);
    assign count_less = count_reg - CNT_W'(1);
    assign edge_rd_addr = slot_reg;
    assign inv_out    = out_valid_reg && (out_kind_reg == KIND_INV);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        id_next      = id_reg;
        cls_next     = cls_reg;
        mode_next    = mode_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        a_next       = a_reg;
        key_next     = key_reg;
        lookup_next  = lookup_reg;
        slot_next    = slot_reg;
        probe_next   = probe_reg;
        inv_next     = inv_reg;
        hash_go_next = 1'b0;
        ans_ok_next  = ans_ok_reg;
        ans_fm_next  = ans_fm_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_ecl_next   = out_ecl_reg;
        out_lcl_next   = out_lcl_reg;
        out_ok_next    = out_ok_reg;
        out_fm_next    = out_fm_reg;
        out_mm_next    = out_mm_reg;
        out_inv_next   = out_inv_reg;
        out_held_next  = out_held_reg;

        edge_wr_en   = 1'b0;
        clr_start    = 1'b0;
        held_rd_addr = idx_reg;
        held_wr_en   = 1'b0;
        held_wr_addr = idx_reg;
        held_wr_data = held_rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    func_next   = func;
                    id_next     = lock_id;
                    cls_next    = lock_class;
                    mode_next   = lock_mode;
                    ans_ok_next = 1'b0;
                    ans_fm_next = 1'b0;
                    case (func)
                        FUNC_ACQUIRE:
                        begin
                            idx_next   = '0;
                            state_next = (track_reg && count_reg != '0) ? S_A_RD : S_PUSH;
                        end
                        FUNC_RELEASE:
                        begin
                            idx_next   = count_less[HW-1:0];
                            state_next = (count_reg != '0) ? S_R_RD : S_ANSWER;
                        end
                        FUNC_QUERY:
                        begin
                            idx_next   = '0;
                            state_next = (count_reg != '0) ? S_Q_RD : S_ANSWER;
                        end
                        default:
                        begin
                            inv_next   = '0;
                            state_next = S_C_OUT;
                        end
                    endcase
                end
            end
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                a_next = held_rd_data.lock_class;
                if (held_rd_data.lock_class == cls_reg)
                begin
                    state_next = S_A_NEXT;
                end
                else
                begin
                    key_next     = {cls_reg, held_rd_data.lock_class};
                    lookup_next  = 1'b1;
                    hash_go_next = 1'b1;
                    state_next   = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    slot_next  = hash_slot;
                    probe_next = '0;
                    state_next = S_P_RD;
                end
            end
            S_P_RD:
            begin
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (edge_rd_data == '0 || edge_rd_data == key_reg)
                begin
                    if (lookup_reg)
                    begin
                        if (edge_rd_data == key_reg)
                        begin
                            state_next = S_INV;
                        end
                        else
                        begin
                            key_next     = {a_reg, cls_reg};
                            lookup_next  = 1'b0;
                            hash_go_next = 1'b1;
                            state_next   = S_HASH;
                        end
                    end
                    else
                    begin
                        edge_wr_en = (edge_rd_data == '0);
                        state_next = S_A_NEXT;
                    end
                end
                else if (probe_reg == LAST_SLOT)
                begin
                    // Table full: absent on lookup, dropped on insert
                    if (lookup_reg)
                    begin
                        key_next     = {a_reg, cls_reg};
                        lookup_next  = 1'b0;
                        hash_go_next = 1'b1;
                        state_next   = S_HASH;
                    end
                    else
                    begin
                        state_next = S_A_NEXT;
                    end
                end
                else
                begin
                    probe_next = probe_reg + EW'(1);
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + EW'(1);
                    state_next = S_P_RD;
                end
            end
            S_INV:
            begin
                if (out_free)
                begin
                    inv_next       = (inv_reg == '1) ? inv_reg : inv_reg + 32'd1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_INV;
                    out_last_next  = 1'b0;
                    out_ecl_next   = a_reg;
                    out_lcl_next   = cls_reg;
                    out_ok_next    = 1'b0;
                    out_fm_next    = 1'b0;
                    out_mm_next    = 1'b0;
                    out_inv_next   = (inv_reg == '1) ? inv_reg : inv_reg + 32'd1;
                    out_held_next  = acq_final;
                    key_next       = {a_reg, cls_reg};
                    lookup_next    = 1'b0;
                    hash_go_next   = 1'b1;
                    state_next     = S_HASH;
                end
            end
            S_A_NEXT:
            begin
                idx_next   = idx_reg + HW'(1);
                state_next = (idx_wide + CNT_W'(1) == count_reg) ? S_PUSH : S_A_RD;
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    held_wr_en     = can_push;
                    held_wr_addr   = count_reg[HW-1:0];
                    held_wr_data   = '{lock_id: id_reg, lock_class: cls_reg,
                                       lock_mode: mode_reg};
                    count_next     = acq_final;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACQUIRE;
                    out_last_next  = 1'b1;
                    out_ecl_next   = '0;
                    out_lcl_next   = '0;
                    out_ok_next    = can_push;
                    out_fm_next    = 1'b0;
                    out_mm_next    = 1'b0;
                    out_inv_next   = inv_reg;
                    out_held_next  = acq_final;
                    state_next     = S_IDLE;
                end
            end
            S_R_RD:
            begin
                state_next = S_R_CHK;
            end
            S_R_CHK:
            begin
                held_rd_addr = count_less[HW-1:0];
                if (held_rd_data.lock_id == id_reg)
                begin
                    ans_ok_next = 1'b1;
                    ans_fm_next = held_rd_data.lock_mode;
                    if (idx_wide == count_less)
                    begin
                        count_next = count_less;
                        state_next = S_ANSWER;
                    end
                    else
                    begin
                        state_next = S_R_MOVE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_ANSWER;
                end
                else
                begin
                    idx_next   = idx_reg - HW'(1);
                    state_next = S_R_RD;
                end
            end
            S_R_MOVE:
            begin
                // Fill the gap with the tail entry
                held_wr_en = 1'b1;
                count_next = count_less;
                state_next = S_ANSWER;
            end
            S_Q_RD:
            begin
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                if (held_rd_data.lock_id == id_reg)
                begin
                    ans_ok_next = 1'b1;
                    ans_fm_next = held_rd_data.lock_mode;
                    state_next  = S_ANSWER;
                end
                else if (idx_wide == count_less)
                begin
                    state_next = S_ANSWER;
                end
                else
                begin
                    idx_next   = idx_reg + HW'(1);
                    state_next = S_Q_RD;
                end
            end
            S_ANSWER:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = (func_reg == FUNC_RELEASE) ? KIND_RELEASE : KIND_QUERY;
                    out_last_next  = 1'b1;
                    out_ecl_next   = '0;
                    out_lcl_next   = '0;
                    out_ok_next    = ans_ok_reg;
                    out_fm_next    = ans_fm_reg;
                    out_mm_next    = (func_reg == FUNC_QUERY) && ans_ok_reg &&
                                     (ans_fm_reg == mode_reg);
                    out_inv_next   = inv_reg;
                    out_held_next  = count_reg;
                    state_next     = S_IDLE;
                end
            end
            S_C_OUT:
            begin
                if (out_free)
                begin
                    clr_start      = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CLEAR;
                    out_last_next  = 1'b1;
                    out_ecl_next   = '0;
                    out_lcl_next   = '0;
                    out_ok_next    = 1'b0;
                    out_fm_next    = 1'b0;
                    out_mm_next    = 1'b0;
                    out_inv_next   = inv_reg;
                    out_held_next  = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            inv_reg       <= '0;
            hash_go_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            inv_reg       <= inv_next;
            hash_go_reg   <= hash_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        id_reg       <= id_next;
        cls_reg      <= cls_next;
        mode_reg     <= mode_next;
        idx_reg      <= idx_next;
        a_reg        <= a_next;
        key_reg      <= key_next;
        lookup_reg   <= lookup_next;
        slot_reg     <= slot_next;
        probe_reg    <= probe_next;
        ans_ok_reg   <= ans_ok_next;
        ans_fm_reg   <= ans_fm_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_ecl_reg  <= out_ecl_next;
        out_lcl_reg  <= out_lcl_next;
        out_ok_reg   <= out_ok_next;
        out_fm_reg   <= out_fm_next;
        out_mm_reg   <= out_mm_next;
        out_inv_reg  <= out_inv_next;
        out_held_reg <= out_held_next;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = out_kind_reg;
    assign last            = out_last_reg;
    assign earlier_class   = out_ecl_reg;
    assign later_class     = out_lcl_reg;
    assign ok              = out_ok_reg;
    assign found_mode      = out_fm_reg;
    assign mode_match      = out_mm_reg;
    assign inversion_total = out_inv_reg;
    assign held_now        = out_held_reg;

    `LOWT_ASSERT(a_held_bound, count_reg <= HELD_MAX, "held count above list size")
    `LOWT_ASSERT_NEXT(a_accept_busy, in_take, state_reg != S_IDLE, "accepted item left idle")
    `LOWT_ASSERT(a_inv_shape, inv_out |-> !(out_ok_reg || out_last_reg), "bad inversion flags")
    `LOWT_ASSERT(a_sweep_stall, clr_busy |-> in_stall, "item taken during edge table sweep")
endmodule
